// ===== design/hslrgb_pkg.sv =====
package hslrgb_pkg;

    localparam int HUE_W    = 11;
    localparam int COMP_W   = 8;
    localparam int T_W      = 9;
    localparam int C2_W     = 16;
    localparam int NUM_W    = 25;
    localparam int SUM_W    = NUM_W + 1;
    localparam int DIV_SH   = 9;
    localparam int Y_W      = SUM_W - DIV_SH;
    localparam int N_STAGES = 5;

    localparam logic [HUE_W-1:0]  HUE_MAX    = 11'd1535;
    localparam logic [COMP_W-1:0] FULL_SCALE = 8'd255;

    // Sector of the hue circle, each 60 degrees wide.
    typedef enum logic [2:0] {
        SEC_RED_YEL = 3'd0,
        SEC_YEL_GRN = 3'd1,
        SEC_GRN_CYN = 3'd2,
        SEC_CYN_BLU = 3'd3,
        SEC_BLU_MAG = 3'd4,
        SEC_MAG_RED = 3'd5
    } t_sector;

    // Load enables for the two stages that sit inside each channel unit.
    typedef struct packed {
        logic load_sum;
        logic load_out;
    } t_pipe_en;

endpackage

// ===== design/hsl_to_rgb_converter_top.sv =====
// HSL to RGB pixel converter. Hue is 0..1535 (six 60-degree sectors of 256
// steps), saturation and lightness are 0..255; the result is 8-bit red,
// green and blue, truncated and clamped. It is a five-stage pipeline that
// takes one word per clock while the output does not stall; an accepted
// word is registered in each stage in turn; the output is the last stage
// register. A stall on the output backs up stage by stage, so empty stages
// still fill while the result waits. The stages follow the arithmetic: the
// first stage finds the sector and the chroma base, the next two hold the
// multipliers (chroma, then the sector term), the last two divide by 255.
module hsl_to_rgb_converter_top
    import hslrgb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [HUE_W-1:0]  i_hue,
    input  logic [COMP_W-1:0] i_saturation,
    input  logic [COMP_W-1:0] i_lightness,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [COMP_W-1:0] o_red,
    output logic [COMP_W-1:0] o_green,
    output logic [COMP_W-1:0] o_blue
);

    logic [N_STAGES-1:0] r_vld;
    logic [N_STAGES-1:0] w_rdy;

    // Stage 1: sector, sector-local term and chroma base.
    logic [HUE_W-1:0]  n_hue;
    t_sector           n_sec;
    logic [T_W-1:0]    n_t;
    logic [COMP_W:0]   n_l2;
    logic [COMP_W:0]   n_dev;
    logic [COMP_W-1:0] n_cb;
    t_sector           r_sec1;
    logic [T_W-1:0]    r_t1;
    logic [COMP_W-1:0] r_cb1;
    logic [COMP_W-1:0] r_s1;
    logic [COMP_W-1:0] r_l1;

    // Stage 2: chroma.
    t_sector           r_sec2;
    logic [T_W-1:0]    r_t2;
    logic [C2_W-1:0]   r_c2;
    logic [COMP_W-1:0] r_l2;

    // Stage 3: numerators.
    logic [NUM_W-2:0]  n_ct;
    logic [NUM_W-1:0]  n_xnum;
    logic [NUM_W-1:0]  n_mnum;
    t_sector           r_sec3;
    logic [NUM_W-1:0]  r_cnum;
    logic [NUM_W-1:0]  r_xnum;
    logic [NUM_W-1:0]  r_mnum;

    logic [NUM_W-1:0]  w_vr;
    logic [NUM_W-1:0]  w_vg;
    logic [NUM_W-1:0]  w_vb;
    t_pipe_en          w_en;

    always_comb begin
        w_rdy[N_STAGES-1] = !r_vld[N_STAGES-1] || i_out_ready;
        for (int k = N_STAGES - 2; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < N_STAGES; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_in_ready  = w_rdy[0];
    assign o_out_valid = r_vld[N_STAGES-1];

    always_comb begin
        n_hue = (i_hue > HUE_MAX) ? HUE_MAX : i_hue;
        n_sec = t_sector'(n_hue[HUE_W-1:8]);
        // Odd sectors run the fraction backward.
        n_t   = n_hue[8] ? (9'd256 - {1'b0, n_hue[7:0]}) : {1'b0, n_hue[7:0]};
        n_l2  = {i_lightness, 1'b0};
        n_dev = (n_l2 >= {1'b0, FULL_SCALE}) ? (n_l2 - {1'b0, FULL_SCALE})
                                             : ({1'b0, FULL_SCALE} - n_l2);
        n_cb  = FULL_SCALE - n_dev[COMP_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_sec1 <= n_sec;
            r_t1   <= n_t;
            r_cb1  <= n_cb;
            r_s1   <= i_saturation;
            r_l1   <= i_lightness;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r_sec2 <= r_sec1;
            r_t2   <= r_t1;
            r_c2   <= C2_W'(r_cb1) * C2_W'(r_s1);
            r_l2   <= r_l1;
        end
    end

    always_comb begin
        n_ct   = (NUM_W-1)'(r_c2) * (NUM_W-1)'(r_t2);
        n_xnum = {n_ct, 1'b0};
        // l * 130560 = l * 2^17 - l * 2^9; the chroma half is never larger.
        n_mnum = {r_l2, 17'd0} - {8'd0, r_l2, 9'd0} - {1'b0, r_c2, 8'd0};
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[2]) begin
            r_sec3 <= r_sec2;
            r_cnum <= {r_c2, 9'd0};
            r_xnum <= n_xnum;
            r_mnum <= n_mnum;
        end
    end

    always_comb begin
        unique case (r_sec3)
            SEC_RED_YEL: begin w_vr = r_cnum; w_vg = r_xnum; w_vb = '0;     end
            SEC_YEL_GRN: begin w_vr = r_xnum; w_vg = r_cnum; w_vb = '0;     end
            SEC_GRN_CYN: begin w_vr = '0;     w_vg = r_cnum; w_vb = r_xnum; end
            SEC_CYN_BLU: begin w_vr = '0;     w_vg = r_xnum; w_vb = r_cnum; end
            SEC_BLU_MAG: begin w_vr = r_xnum; w_vg = '0;     w_vb = r_cnum; end
            default:     begin w_vr = r_cnum; w_vg = '0;     w_vb = r_xnum; end
        endcase
    end

    assign w_en.load_sum = w_rdy[3];
    assign w_en.load_out = w_rdy[4];

    hslrgb_chan u_red (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_vnum (w_vr),
        .i_mnum (r_mnum),
        .o_chan (o_red)
    );

    hslrgb_chan u_green (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_vnum (w_vg),
        .i_mnum (r_mnum),
        .o_chan (o_green)
    );

    hslrgb_chan u_blue (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_vnum (w_vb),
        .i_mnum (r_mnum),
        .o_chan (o_blue)
    );

endmodule

// ===== design/hslrgb_chan.sv =====
module hslrgb_chan
    import hslrgb_pkg::*;
(
    input  logic              i_clk,
    input  t_pipe_en          i_en,
    input  logic [NUM_W-1:0]  i_vnum,
    input  logic [NUM_W-1:0]  i_mnum,
    output logic [COMP_W-1:0] o_chan
);

    logic [SUM_W-1:0]  n_sum;
    logic [Y_W-1:0]    r_y;
    logic [COMP_W-1:0] n_q0;
    logic [COMP_W:0]   n_rem;
    logic [COMP_W-1:0] n_chan;
    logic [COMP_W-1:0] r_chan;

    // The full divisor is 255 * 512: the shift takes the 512 exactly.
    assign n_sum = {1'b0, i_vnum} + {1'b0, i_mnum};

    always_ff @(posedge i_clk) begin
        if (i_en.load_sum) begin
            r_y <= n_sum[SUM_W-1:DIV_SH];
        end
    end

    // Below 255 * 256 the estimate y / 256 is short by at most one, and the
    // remainder y - 255 * q0 equals the low byte plus q0.
    always_comb begin
        n_q0  = r_y[2*COMP_W-1:COMP_W];
        n_rem = {1'b0, r_y[COMP_W-1:0]} + {1'b0, n_q0};
        if (r_y >= Y_W'({FULL_SCALE, 8'd0})) begin
            n_chan = FULL_SCALE;
        end else if (n_rem >= {1'b0, FULL_SCALE}) begin
            n_chan = n_q0 + 8'd1;
        end else begin
            n_chan = n_q0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.load_out) begin
            r_chan <= n_chan;
        end
    end

    assign o_chan = r_chan;

endmodule

// ===== design/hslrgb_checker.sv =====
module hslrgb_checker
    import hslrgb_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input logic [HUE_W-1:0]  i_hue,
    input logic [COMP_W-1:0] i_saturation,
    input logic [COMP_W-1:0] i_lightness,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic [COMP_W-1:0] o_red,
    input logic [COMP_W-1:0] o_green,
    input logic [COMP_W-1:0] o_blue
);

    // A word waiting at the output stays until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid &&
            $stable(o_red) && $stable(o_green) && $stable(o_blue))
        else $error("output word changed while stalled");

    // With nothing at the output, every stage can move, so input is open.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input blocked while output is empty");

    // The pipeline comes out of reset empty.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // A word accepted into an open pipeline reaches the output while it stays open.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_out_ready ##1 i_out_ready ##1 i_out_ready
            ##1 i_out_ready ##1 i_out_ready |=> o_out_valid)
        else $error("accepted word did not reach the output in time");

endmodule

bind hsl_to_rgb_converter_top hslrgb_checker u_hslrgb_checker (.*);
